[rtl/rs485_nine_bit_framer_unit_assert.svh]
// assertion macros for the rs485 nine-bit framer
// depends on i_clk and i_rst_n being visible where the macros are used
`ifndef RS485_NINE_BIT_FRAMER_UNIT_ASSERT_SVH
`define RS485_NINE_BIT_FRAMER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RNF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rnf assertion failed");

// next-cycle implication, checked outside reset
`define RNF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rnf assertion failed");

`endif

[rtl/rnf_pkg.sv]
// shared types and constants of the rs485 nine-bit framer
// no dependencies
`default_nettype none

package rnf_pkg;

    localparam int MAX_WORDS = 5;
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);

    typedef logic [8:0] t_word;
    typedef logic [1:0] t_status;

    localparam logic    OP_START = 1'b0;
    localparam logic    OP_BYTE  = 1'b1;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_LEN_ERR  = 2'd1;
    localparam t_status ST_NO_FRAME = 2'd2;

    localparam t_word   START_MARK = 9'h100;

    typedef struct packed {
        logic [MAX_WORDS-1:0][8:0] words;
        t_status                   status;
        logic [CNT_W-1:0]          num;
    } t_burst;

endpackage

`default_nettype wire

[rtl/rnf_ifs.sv]
// request and result channel interfaces of the rs485 nine-bit framer
// no dependencies
`default_nettype none

interface rnf_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] dest_addr;
    logic [7:0] payload_len;
    logic [7:0] data_byte;

    modport source (output valid, operation, dest_addr, payload_len, data_byte, input ready);
    modport sink   (input valid, operation, dest_addr, payload_len, data_byte, output ready);
endinterface

interface rnf_res_if;
    logic       valid;
    logic       ready;
    logic [8:0] line_word;
    logic [1:0] status;
    logic       last_of_run;

    modport source (output valid, line_word, status, last_of_run, input ready);
    modport sink   (input valid, line_word, status, last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/rs485_nine_bit_framer_unit.sv]
// Nine-bit RS-485 frame builder. A payload byte request gives one word (three when it
// closes the frame); a start request gives three words, or five for a zero-length frame,
// and one word for an error. A request is accepted while no word is pending or in the
// cycle the last word of the previous one is taken, so payload bytes that do not close
// the frame go at one request per cycle while the result side is ready; results leave a
// five-word shift register, the first in the cycle after its request is accepted.
// Depends on rnf_pkg, rnf_ifs, rnf_core, rnf_emitter and the assertion header.
`default_nettype none

`include "rs485_nine_bit_framer_unit_assert.svh"

module rs485_nine_bit_framer_unit
    import rnf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    rnf_req_if.sink         i_req,
    rnf_res_if.source       o_res
);

    logic [7:0] r_station_id;
    logic       req_accept;
    logic       res_take;
    logic       res_valid;
    logic       res_last;
    t_burst     burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_id <= '0;
        end else if (i_cfg_we) begin
            r_station_id <= i_cfg_wdata;
        end
    end

    assign res_take    = res_valid && o_res.ready;
    assign i_req.ready = !res_valid || (res_take && res_last);
    assign req_accept  = i_req.valid && i_req.ready;

    rnf_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (req_accept),
        .i_operation   (i_req.operation),
        .i_dest_addr   (i_req.dest_addr),
        .i_payload_len (i_req.payload_len),
        .i_data_byte   (i_req.data_byte),
        .i_station_id  (r_station_id),
        .o_burst       (burst)
    );

    rnf_emitter u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (req_accept),
        .i_burst  (burst),
        .i_take   (res_take),
        .o_valid  (res_valid),
        .o_last   (res_last),
        .o_word   (o_res.line_word),
        .o_status (o_res.status)
    );

    assign o_res.valid       = res_valid;
    assign o_res.last_of_run = res_last;

    `RNF_ASSERT_NOW(a_err_single, o_res.valid && o_res.status != ST_OK, o_res.last_of_run && o_res.line_word == 9'd0)
    `RNF_ASSERT_NOW(a_no_overrun, req_accept, !(o_res.valid && !o_res.last_of_run))
    `RNF_ASSERT_NEXT(a_start_mark, req_accept && i_req.operation == OP_START && i_req.payload_len <= 8'(MAX_PAYLOAD), o_res.valid && o_res.line_word[8])

endmodule

`default_nettype wire

[rtl/rnf_core.sv]
// frame state and word generation of the rs485 nine-bit framer
// depends on rnf_pkg
`default_nettype none

module rnf_core
    import rnf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_dest_addr,
    input  wire logic [7:0] i_payload_len,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [7:0] i_station_id,
    output t_burst          o_burst
);

    localparam int         LW      = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [LW-1:0] r_left, n_left;
    logic [7:0]    r_check, n_check;
    logic          r_open, n_open;

    logic [7:0]    seed;
    logic [7:0]    byte_check;

    assign seed       = i_station_id ^ i_dest_addr ^ i_payload_len;
    assign byte_check = r_check ^ i_data_byte;

    always_comb begin
        n_left  = r_left;
        n_check = r_check;
        n_open  = r_open;
        o_burst = '0;
        if (i_operation == OP_START) begin
            n_left  = '0;
            n_check = '0;
            n_open  = 1'b0;
            if (i_payload_len > MAX_LEN) begin
                o_burst.status = ST_LEN_ERR;
                o_burst.num    = CNT_W'(1);
            end else begin
                o_burst.words[0] = START_MARK | {1'b0, i_payload_len};
                o_burst.words[1] = {1'b0, i_station_id};
                o_burst.words[2] = {1'b0, i_dest_addr};
                if (i_payload_len == 8'd0) begin
                    o_burst.words[3] = {1'b0, seed};
                    o_burst.num      = CNT_W'(5);
                end else begin
                    o_burst.num = CNT_W'(3);
                    n_left      = i_payload_len[LW-1:0];
                    n_check     = seed;
                    n_open      = 1'b1;
                end
            end
        end else if (!r_open) begin
            o_burst.status = ST_NO_FRAME;
            o_burst.num    = CNT_W'(1);
        end else begin
            o_burst.words[0] = {1'b0, i_data_byte};
            if (r_left == LW'(1)) begin
                o_burst.words[1] = {1'b0, byte_check};
                o_burst.num      = CNT_W'(3);
                n_left           = '0;
                n_check          = '0;
                n_open           = 1'b0;
            end else begin
                o_burst.num = CNT_W'(1);
                n_left      = r_left - LW'(1);
                n_check     = byte_check;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_check <= '0;
            r_open  <= 1'b0;
        end else if (i_accept) begin
            r_left  <= n_left;
            r_check <= n_check;
            r_open  <= n_open;
        end
    end

endmodule

`default_nettype wire

[rtl/rnf_emitter.sv]
// result shift register of the rs485 nine-bit framer, up to five words per request
// depends on rnf_pkg
`default_nettype none

module rnf_emitter
    import rnf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_burst i_burst,
    input  wire logic   i_take,
    output logic        o_valid,
    output logic        o_last,
    output t_word       o_word,
    output t_status     o_status
);

    logic [MAX_WORDS-1:0][8:0] r_words, n_words;
    t_status                   r_status;
    logic [CNT_W-1:0]          r_left, n_left;

    always_comb begin
        n_words = r_words;
        n_left  = r_left;
        if (i_load) begin
            n_words = i_burst.words;
            n_left  = i_burst.num;
        end else if (i_take) begin
            n_words = {9'd0, r_words[MAX_WORDS-1:1]};
            n_left  = r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
        if (i_load) begin
            r_status <= i_burst.status;
        end
    end

    assign o_valid  = (r_left != '0);
    assign o_last   = (r_left == CNT_W'(1));
    assign o_word   = r_words[0];
    assign o_status = r_status;

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking testbench of the rs485 nine-bit framer unit: a frame word predictor in a
// small scoreboard class, request and result drivers with random idling and stalls
// depends on rnf_pkg, rnf_ifs and rs485_nine_bit_framer_unit
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rnf_pkg::*;

    localparam int FRAME_MAX   = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 50;

    typedef struct packed {
        t_word   word;
        t_status status;
        logic    last;
    } frame_word_t;

    class framer_scoreboard;
        bit [7:0]    station_id;
        bit [5:0]    bytes_left;
        bit [7:0]    checksum;
        bit          frame_open;
        int          mismatches;
        frame_word_t line_words[$];

        function void add_word(t_word w, t_status s);
            frame_word_t fw;
            fw.word   = w;
            fw.status = s;
            fw.last   = 1'b0;
            line_words.push_back(fw);
        endfunction

        function void close_frame();
            add_word({1'b0, checksum}, ST_OK);
            add_word('0, ST_OK);
            frame_open = 1'b0;
            bytes_left = '0;
            checksum   = '0;
        endfunction

        function void note_request(logic op, logic [7:0] dest, logic [7:0] len,
                                   logic [7:0] data);
            frame_word_t fw;
            if (op == OP_START) begin
                frame_open = 1'b0;
                bytes_left = '0;
                checksum   = '0;
                if (len > FRAME_MAX) begin
                    add_word('0, ST_LEN_ERR);
                end else begin
                    add_word(START_MARK | {1'b0, len}, ST_OK);
                    add_word({1'b0, station_id}, ST_OK);
                    add_word({1'b0, dest}, ST_OK);
                    checksum = station_id ^ dest ^ len;
                    if (len == 0) begin
                        close_frame();
                    end else begin
                        bytes_left = len[5:0];
                        frame_open = 1'b1;
                    end
                end
            end else if (!frame_open) begin
                add_word('0, ST_NO_FRAME);
            end else begin
                add_word({1'b0, data}, ST_OK);
                checksum   = checksum ^ data;
                bytes_left = bytes_left - 6'd1;
                if (bytes_left == 0) begin
                    close_frame();
                end
            end
            fw = line_words.pop_back();
            fw.last = 1'b1;
            line_words.push_back(fw);
        endfunction

        function void check_result(t_word w, t_status s, logic last);
            frame_word_t fw;
            if (line_words.size() == 0) begin
                $display("%0t unexpected word: expected none, actual %h status %0d last %0b",
                         $time, w, s, last);
                mismatches++;
                return;
            end
            fw = line_words.pop_front();
            if (w !== fw.word) begin
                $display("%0t line_word: expected %h, actual %h", $time, fw.word, w);
                mismatches++;
            end
            if (s !== fw.status) begin
                $display("%0t status: expected %0d, actual %0d", $time, fw.status, s);
                mismatches++;
            end
            if (last !== fw.last) begin
                $display("%0t last_of_run: expected %0b, actual %0b", $time, fw.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    rnf_req_if req_if ();
    rnf_res_if res_if ();

    framer_scoreboard sb;
    int unsigned      send_idle;
    int unsigned      recv_stall;
    int               items_sent;
    int               cycles;

    rs485_nine_bit_framer_unit #(
        .MAX_PAYLOAD (FRAME_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: check taken words, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                sb.check_result(res_if.line_word, res_if.status, res_if.last_of_run);
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_req(input logic op, input logic [7:0] dest, input logic [7:0] len,
                            input logic [7:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle) begin
            gap++;
        end
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.dest_addr   <= dest;
        req_if.payload_len <= len;
        req_if.data_byte   <= data;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        sb.note_request(op, dest, len, data);
        items_sent++;
    endtask

    task automatic send_start(input logic [7:0] dest, input logic [7:0] len);
        send_req(OP_START, dest, len, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_req(OP_BYTE, 8'($urandom), 8'($urandom), data);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (sb.line_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_station_id(input logic [7:0] id);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= id;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.station_id = id;
        @(posedge i_clk);
    endtask

    // mostly whole frames, some abandoned, plus length errors and stray bytes
    task automatic random_frame();
        int unsigned pick;
        int unsigned len;
        int unsigned sent_bytes;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_byte(8'($urandom));
        end else if (pick < 14) begin
            send_start(8'($urandom), 8'($urandom_range(255, FRAME_MAX + 1)));
        end else begin
            pick = $urandom_range(99);
            if (pick < 12) len = FRAME_MAX;
            else if (pick < 24) len = 0;
            else if (pick < 40) len = $urandom_range(FRAME_MAX - 1, 9);
            else len = $urandom_range(8, 1);
            sent_bytes = len;
            if (len > 0 && $urandom_range(99) < 10) begin
                sent_bytes = $urandom_range(len - 1, 0);
            end
            send_start(8'($urandom), 8'(len));
            repeat (sent_bytes) send_byte(8'($urandom));
        end
    endtask

    task automatic run_phase(input logic [7:0] id, input int unsigned idle_pct,
                             input int unsigned stall_pct);
        int target;
        write_station_id(id);
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            random_frame();
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        send_idle          = 0;
        recv_stall         = 0;
        items_sent         = 0;
        cycles             = 0;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        req_if.valid       <= 1'b0;
        req_if.operation   <= OP_START;
        req_if.dest_addr   <= '0;
        req_if.payload_len <= '0;
        req_if.data_byte   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at the reset station id
        send_byte(8'h00);
        send_start(8'h00, 8'd0);
        send_start(8'hFF, 8'd33);
        send_start(8'h12, 8'd255);
        send_start(8'hAA, 8'd1);
        send_byte(8'hFF);
        send_start(8'h55, 8'd2);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        // start over an open frame
        send_start(8'h01, 8'd3);
        send_byte(8'h3C);
        send_start(8'h80, 8'd0);
        // length error over an open frame, then a stray byte
        send_start(8'h7E, 8'd4);
        send_byte(8'h01);
        send_start(8'h33, 8'd40);
        send_byte(8'hC3);
        send_start(8'hFF, 8'd0);
        wait_drained();

        run_phase(8'hFF, 0, 0);
        run_phase(8'($urandom), 58, 0);
        run_phase(8'h00, 0, 58);
        run_phase(8'($urandom), 13, 13);
        run_phase(8'hFF, 58, 58);

        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
